/* src/ssp_pkg.sv */
// Shared types, constants, coefficient tables and microprogram of the sound speed block.
package ssp_pkg;

  localparam int DEPTH_W = 14;
  localparam int TEMP_W  = 17;
  localparam int SAL_W   = 16;
  localparam int LAT_W   = 17;
  localparam int VEL_W   = 21;
  localparam int unsigned VEL_MAX = 2000000;
  localparam int QUEUE_DEPTH = 2;

  localparam int REG_AW   = 3;
  localparam int PC_W     = 6;
  localparam int NUM_UOPS = 53;
  localparam int K_COUNT  = 24;

  typedef logic signed [63:0] word_t;
  typedef logic [63:0] ktab_t [K_COUNT];

  typedef enum logic [1:0] {SH_20, SH_40, SH_60} shift_t;
  typedef enum logic [1:0] {SRC_REG, SRC_K60, SRC_K40, SRC_IN} src_t;
  typedef enum logic {OP_ADD, OP_MUL} op_t;
  typedef enum logic [1:0] {BK_IDLE, BK_FETCH, BK_EXEC, BK_MULW} back_state_t;

  typedef struct packed {
    src_t       kind;
    logic [4:0] idx;
  } opnd_t;

  typedef struct packed {
    op_t               op;
    opnd_t             a;
    opnd_t             b;
    logic [REG_AW-1:0] dst;
    shift_t            sh;
    logic              last;
  } uop_t;

  // one request as handed from front to back
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [TEMP_W-1:0]  temp;
    logic [SAL_W-1:0]   sal;
    logic               have;
    logic               held;
  } item_t;

  // coefficient indexes
  localparam logic [4:0] K_MILLI = 5'd0;
  localparam logic [4:0] K_LAT   = 5'd1;
  localparam logic [4:0] K_LIN   = 5'd2;
  localparam logic [4:0] K_QUAD  = 5'd3;
  localparam logic [4:0] K_KG    = 5'd4;
  localparam logic [4:0] K_C0    = 5'd5;
  localparam logic [4:0] K_T1    = 5'd6;
  localparam logic [4:0] K_T2    = 5'd7;
  localparam logic [4:0] K_T3    = 5'd8;
  localparam logic [4:0] K_S1    = 5'd9;
  localparam logic [4:0] K_S2    = 5'd10;
  localparam logic [4:0] K_P1    = 5'd11;
  localparam logic [4:0] K_P2    = 5'd12;
  localparam logic [4:0] K_P3    = 5'd13;
  localparam logic [4:0] K_TP    = 5'd14;
  localparam logic [4:0] K_A     = 5'd15;
  localparam logic [4:0] K_B     = 5'd16;
  localparam logic [4:0] K_C     = 5'd17;
  localparam logic [4:0] K_D     = 5'd18;
  localparam logic [4:0] K_E     = 5'd19;
  localparam logic [4:0] K_F     = 5'd20;
  localparam logic [4:0] K_G     = 5'd21;
  localparam logic [4:0] K_H     = 5'd22;
  localparam logic [4:0] K_J     = 5'd23;

  // input operand selectors
  localparam logic [4:0] IN_T        = 5'd0;
  localparam logic [4:0] IN_S        = 5'd1;
  localparam logic [4:0] IN_Z        = 5'd2;
  localparam logic [4:0] IN_LAT      = 5'd3;
  localparam logic [4:0] IN_ONE      = 5'd4;
  localparam logic [4:0] IN_THOUSAND = 5'd5;

  // scratch registers
  localparam logic [REG_AW-1:0] R_T = 3'd0;
  localparam logic [REG_AW-1:0] R_S = 3'd1;
  localparam logic [REG_AW-1:0] R_P = 3'd2;
  localparam logic [REG_AW-1:0] R_X = 3'd3;
  localparam logic [REG_AW-1:0] R_Y = 3'd4;
  localparam logic [REG_AW-1:0] R_V = 3'd5;

  localparam logic [63:0] K_NUM [K_COUNT] = '{
    64'd1, 64'd528, 64'd10052405, 64'd236, 64'd1019716, 64'd1402392,
    64'd501109398873, 64'd550946843172, 64'd221535969240, 64'd132952290781,
    64'd128955756844, 64'd156059257041, 64'd24499868841, 64'd8833923325,
    64'd635191613389, 64'd26548471661, 64'd159349479045, 64'd522116437,
    64'd438031096213, 64'd127562783426, 64'd1616744959, 64'd968403156410,
    64'd485639620015, 64'd340597039004};

  localparam logic [63:0] K_DEN [K_COUNT] = '{
    64'd1000, 64'd100000, 64'd10000000, 64'd100000000, 64'd10000000, 64'd1000,
    64'd100000000000, 64'd10000000000000, 64'd1000000000000000,
    64'd100000000000, 64'd1000000000000000, 64'd1000000000000,
    64'd1000000000000000, 64'd1000000000000000000, 64'd100000000000000,
    64'd1000000000000000000, 64'd100000000000000000, 64'd1000000000000000000,
    64'd1000000000000000000, 64'd10000000000000, 64'd1000000000000000000,
    64'd10000000000000000, 64'd100000000000000000, 64'd1000000000000000};

  localparam logic [K_COUNT-1:0] K_NEG = 24'b1001_1101_0010_0000_1000_0000;

  // round(num / den * 2^bits), ties up, by restoring long division
  function automatic logic [63:0] coef_calc(input logic [63:0] num, input logic [63:0] den,
                                            input logic neg, input int bits);
    logic [127:0] n;
    logic [127:0] q;
    logic [64:0]  r;
    logic [63:0]  mag;
    n = {64'd0, num} << bits;
    q = '0;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    mag = q[63:0];
    if ({r[63:0], 1'b0} >= {1'b0, den}) begin
      mag = mag + 64'd1;
    end
    return neg ? (64'd0 - mag) : mag;
  endfunction

  function automatic ktab_t build_tab(input int bits);
    ktab_t t;
    for (int i = 0; i < K_COUNT; i++) begin
      t[i] = coef_calc(K_NUM[i], K_DEN[i], K_NEG[i], bits);
    end
    return t;
  endfunction

  localparam ktab_t K60_TAB = build_tab(60);
  localparam ktab_t K40_TAB = build_tab(40);

  function automatic opnd_t opr(input logic [REG_AW-1:0] i);
    return '{kind: SRC_REG, idx: 5'(i)};
  endfunction
  function automatic opnd_t ok60(input logic [4:0] i);
    return '{kind: SRC_K60, idx: i};
  endfunction
  function automatic opnd_t ok40(input logic [4:0] i);
    return '{kind: SRC_K40, idx: i};
  endfunction
  function automatic opnd_t oin(input logic [4:0] i);
    return '{kind: SRC_IN, idx: i};
  endfunction

  function automatic uop_t mul(input opnd_t a, input opnd_t b, input logic [REG_AW-1:0] d,
                               input shift_t sh);
    return '{op: OP_MUL, a: a, b: b, dst: d, sh: sh, last: 1'b0};
  endfunction
  function automatic uop_t add(input opnd_t a, input opnd_t b, input logic [REG_AW-1:0] d);
    return '{op: OP_ADD, a: a, b: b, dst: d, sh: SH_40, last: 1'b0};
  endfunction

  // pressure, then the speed polynomial term by term into R_V, then scale to mm/s
  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mul(oin(IN_T), ok60(K_MILLI), R_T, SH_20);
      6'd1:  u = mul(oin(IN_S), ok60(K_MILLI), R_S, SH_20);
      6'd2:  u = mul(ok60(K_LAT), oin(IN_LAT), R_P, SH_60);
      6'd3:  u = add(oin(IN_ONE), opr(R_P), R_P);
      6'd4:  u = mul(ok60(K_LIN), oin(IN_Z), R_X, SH_60);
      6'd5:  u = mul(opr(R_X), opr(R_P), R_X, SH_40);
      6'd6:  u = mul(ok60(K_QUAD), oin(IN_Z), R_Y, SH_60);
      6'd7:  u = mul(opr(R_Y), oin(IN_Z), R_Y, SH_40);
      6'd8:  u = add(opr(R_X), opr(R_Y), R_X);
      6'd9:  u = mul(ok60(K_KG), opr(R_X), R_P, SH_60);
      6'd10: u = mul(ok60(K_T3), opr(R_T), R_X, SH_60);
      6'd11: u = add(ok40(K_T2), opr(R_X), R_X);
      6'd12: u = mul(opr(R_T), opr(R_X), R_X, SH_40);
      6'd13: u = add(ok40(K_T1), opr(R_X), R_X);
      6'd14: u = mul(opr(R_T), opr(R_X), R_X, SH_40);
      6'd15: u = add(ok40(K_C0), opr(R_X), R_V);
      6'd16: u = mul(ok60(K_S2), opr(R_S), R_X, SH_60);
      6'd17: u = add(ok40(K_S1), opr(R_X), R_X);
      6'd18: u = mul(opr(R_S), opr(R_X), R_X, SH_40);
      6'd19: u = add(opr(R_V), opr(R_X), R_V);
      6'd20: u = mul(ok60(K_P3), opr(R_P), R_X, SH_60);
      6'd21: u = add(ok40(K_P2), opr(R_X), R_X);
      6'd22: u = mul(opr(R_P), opr(R_X), R_X, SH_40);
      6'd23: u = add(ok40(K_P1), opr(R_X), R_X);
      6'd24: u = mul(opr(R_P), opr(R_X), R_X, SH_40);
      6'd25: u = add(opr(R_V), opr(R_X), R_V);
      6'd26: u = mul(ok60(K_A), opr(R_T), R_X, SH_60);
      6'd27: u = add(ok40(K_B), opr(R_X), R_X);
      6'd28: u = mul(ok60(K_C), opr(R_P), R_Y, SH_60);
      6'd29: u = add(opr(R_X), opr(R_Y), R_X);
      6'd30: u = mul(opr(R_P), opr(R_X), R_X, SH_40);
      6'd31: u = add(ok40(K_TP), opr(R_X), R_X);
      6'd32: u = mul(ok60(K_D), opr(R_T), R_Y, SH_60);
      6'd33: u = mul(opr(R_Y), opr(R_T), R_Y, SH_40);
      6'd34: u = add(opr(R_X), opr(R_Y), R_X);
      6'd35: u = mul(opr(R_P), opr(R_X), R_X, SH_40);
      6'd36: u = mul(ok60(K_E), opr(R_S), R_Y, SH_60);
      6'd37: u = add(opr(R_Y), opr(R_X), R_X);
      6'd38: u = mul(opr(R_T), opr(R_X), R_X, SH_40);
      6'd39: u = add(opr(R_V), opr(R_X), R_V);
      6'd40: u = mul(ok60(K_H), opr(R_S), R_X, SH_60);
      6'd41: u = add(opr(R_X), ok40(K_J), R_X);
      6'd42: u = mul(opr(R_P), opr(R_X), R_X, SH_40);
      6'd43: u = mul(ok60(K_G), opr(R_T), R_Y, SH_60);
      6'd44: u = add(opr(R_Y), opr(R_X), R_X);
      6'd45: u = mul(opr(R_T), opr(R_X), R_X, SH_40);
      6'd46: u = mul(ok60(K_F), opr(R_S), R_Y, SH_60);
      6'd47: u = mul(opr(R_Y), opr(R_P), R_Y, SH_40);
      6'd48: u = mul(opr(R_Y), opr(R_P), R_Y, SH_40);
      6'd49: u = add(opr(R_Y), opr(R_X), R_X);
      6'd50: u = mul(opr(R_S), opr(R_X), R_X, SH_40);
      6'd51: u = add(opr(R_V), opr(R_X), R_V);
      6'd52: begin
        u = mul(opr(R_V), oin(IN_THOUSAND), R_X, SH_40);
        u.last = 1'b1;
      end
      default: u = add(opr(R_X), opr(R_X), R_X);
    endcase
    return u;
  endfunction

endpackage

/* src/sound_speed_profile_delgrosso_top.sv */
// Top level of the profile sound speed block.
//
// Requests arrive on req_valid/req_stall, one depth level each, and are taken
// at a rising edge with req_valid high and req_stall low. Every request gives
// one result on rsp_valid/rsp_stall, in order. cfg_we writes lat_sin_sq_q16
// (sin^2 of latitude, Q16) from cfg_data; write it only while the block is idle.
//
// The front end updates the held sample and queues each level. The back end
// runs a 53-step microprogram over one shared multi-cycle 64x64 multiplier
// (four 32x32 partial products, a rounding add and a cap stage) and an adder.
// A level with a sample runs 33 multiplies and 20 additions on its way from
// queue to result register. A level before the first sample of its profile
// is answered with an invalid result, without running the microprogram.
// The queue holds two levels, so the front keeps taking requests while the
// back end works; req_stall rises only when the queue is full.
//
// Reset (rst, synchronous) clears the held sample, the queue, the sequencer,
// the result valid flag and the latitude register. While rsp_stall is high the
// result holds and the back end waits before starting the next level.
module sound_speed_profile_delgrosso_top #(
  parameter int QUEUE_DEPTH = ssp_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ssp_pkg::LAT_W-1:0]         cfg_data,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [ssp_pkg::DEPTH_W-1:0]       depth_m,
  input  logic signed [ssp_pkg::TEMP_W-1:0] temperature_mc,
  input  logic [ssp_pkg::SAL_W-1:0]         salinity_mpsu,
  input  logic                              sample_valid,
  input  logic                              profile_start,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [ssp_pkg::VEL_W-1:0]         velocity_mmps,
  output logic                              velocity_valid,
  output logic                              from_held
);

  logic           q_push, q_pop, q_full, q_not_empty;
  ssp_pkg::item_t push_item, head_item;

  ssp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .depth_m        (depth_m),
    .temperature_mc (temperature_mc),
    .salinity_mpsu  (salinity_mpsu),
    .sample_valid   (sample_valid),
    .profile_start  (profile_start),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  ssp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  ssp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .q_valid        (q_not_empty),
    .q_item         (head_item),
    .q_pop          (q_pop),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .velocity_mmps  (velocity_mmps),
    .velocity_valid (velocity_valid),
    .from_held      (from_held)
  );

endmodule

/* src/ssp_front.sv */
// Front end: takes requests, tracks the held sample and classifies each level.
module ssp_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [ssp_pkg::DEPTH_W-1:0]  depth_m,
  input  logic signed [ssp_pkg::TEMP_W-1:0] temperature_mc,
  input  logic [ssp_pkg::SAL_W-1:0]    salinity_mpsu,
  input  logic                         sample_valid,
  input  logic                         profile_start,
  input  logic                         q_full,
  output logic                         q_push,
  output ssp_pkg::item_t               q_item
);

  logic [ssp_pkg::TEMP_W-1:0] held_temperature, held_temperature_next;
  logic [ssp_pkg::SAL_W-1:0]  held_salinity, held_salinity_next;
  logic                       have_sample, have_sample_next;
  logic                       base_have;

  assign req_stall = q_full;
  assign q_push    = req_valid && !q_full;

  always_comb begin
    // a new profile drops the held sample before this level is looked at
    base_have             = profile_start ? 1'b0 : have_sample;
    held_temperature_next = profile_start ? '0 : held_temperature;
    held_salinity_next    = profile_start ? '0 : held_salinity;
    if (sample_valid) begin
      held_temperature_next = temperature_mc;
      held_salinity_next    = salinity_mpsu;
    end
    have_sample_next = sample_valid || base_have;
    q_item.depth = depth_m;
    q_item.temp  = held_temperature_next;
    q_item.sal   = held_salinity_next;
    q_item.have  = have_sample_next;
    q_item.held  = !sample_valid && base_have;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_temperature <= '0;
      held_salinity    <= '0;
      have_sample      <= 1'b0;
    end else if (q_push) begin
      held_temperature <= held_temperature_next;
      held_salinity    <= held_salinity_next;
      have_sample      <= have_sample_next;
    end
  end

endmodule

/* src/ssp_queue.sv */
// Short queue between the front and back ends.
module ssp_queue #(
  parameter int DEPTH = ssp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ssp_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output ssp_pkg::item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssp_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* src/ssp_mul.sv */
// Multi-cycle signed 64x64 multiplier with rounded shift and magnitude cap.
module ssp_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ssp_pkg::word_t  a,
  input  ssp_pkg::word_t  b,
  input  ssp_pkg::shift_t sh,
  output logic            done,
  output ssp_pkg::word_t  result
);

  localparam logic [63:0] MAG_LIMIT = 64'd1 << 62;

  logic [63:0]     ua, ub;
  logic            neg;
  ssp_pkg::shift_t shr;
  logic [2:0]      cnt;
  logic [127:0]    acc;
  logic [31:0]     pa, pb;
  logic [63:0]     pp;
  logic [127:0]    pp_ext;
  logic [127:0]    round_add;
  logic [127:0]    shifted;
  logic [63:0]     mag;

  always_comb begin
    unique case (cnt)
      3'd1:    begin pa = ua[31:0];  pb = ub[31:0];  end
      3'd2:    begin pa = ua[31:0];  pb = ub[63:32]; end
      3'd3:    begin pa = ua[63:32]; pb = ub[31:0];  end
      3'd4:    begin pa = ua[63:32]; pb = ub[63:32]; end
      default: begin pa = '0;        pb = '0;        end
    endcase
    pp = pa * pb;
    unique case (cnt)
      3'd1:         pp_ext = {64'd0, pp};
      3'd2, 3'd3:   pp_ext = {32'd0, pp, 32'd0};
      default:      pp_ext = {pp, 64'd0};
    endcase
    unique case (shr)
      ssp_pkg::SH_20: begin round_add = 128'd1 << 19; shifted = acc >> 20; end
      ssp_pkg::SH_40: begin round_add = 128'd1 << 39; shifted = acc >> 40; end
      default:        begin round_add = 128'd1 << 59; shifted = acc >> 60; end
    endcase
    // cap the magnitude at 2^62
    if (shifted[127:64] != '0 || shifted[63:0] > MAG_LIMIT) begin
      mag = MAG_LIMIT;
    end else begin
      mag = shifted[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == 3'd6);
      if (start) begin
        cnt <= 3'd1;
      end else if (cnt == 3'd6) begin
        cnt <= '0;
      end else if (cnt != '0) begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua  <= a[63] ? (64'd0 - a) : a;
      ub  <= b[63] ? (64'd0 - b) : b;
      neg <= a[63] ^ b[63];
      shr <= sh;
      acc <= '0;
    end else if (cnt >= 3'd1 && cnt <= 3'd4) begin
      acc <= acc + pp_ext;
    end else if (cnt == 3'd5) begin
      acc <= acc + round_add;
    end else if (cnt == 3'd6) begin
      result <= neg ? (64'sd0 - $signed(mag)) : $signed(mag);
    end
  end

endmodule

/* src/ssp_back.sv */
// Back end: runs the pressure and speed microprogram on one level at a time.
module ssp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ssp_pkg::LAT_W-1:0]  cfg_data,
  input  logic                       q_valid,
  input  ssp_pkg::item_t             q_item,
  output logic                       q_pop,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [ssp_pkg::VEL_W-1:0]  velocity_mmps,
  output logic                       velocity_valid,
  output logic                       from_held
);

  ssp_pkg::back_state_t           state, state_next;
  logic [ssp_pkg::PC_W-1:0]       pc, pc_next;
  ssp_pkg::item_t                 cur;
  logic [ssp_pkg::LAT_W-1:0]      lat_sin_sq_q16;
  logic                           v_pos;
  ssp_pkg::word_t                 rf [2**ssp_pkg::REG_AW];
  ssp_pkg::word_t                 rda, rdb;
  ssp_pkg::uop_t                  uop;
  ssp_pkg::word_t                 opa, opb;
  logic                           rf_we;
  ssp_pkg::word_t                 rf_wdata;
  logic                           mul_start, mul_done;
  ssp_pkg::word_t                 mul_res;
  logic                           load_zero, load_res;
  logic [ssp_pkg::VEL_W-1:0]      vel_res;

  function automatic ssp_pkg::word_t pick(input ssp_pkg::opnd_t o, input ssp_pkg::word_t rd,
                                          input ssp_pkg::item_t it,
                                          input logic [ssp_pkg::LAT_W-1:0] lat);
    ssp_pkg::word_t v;
    v = '0;
    unique case (o.kind)
      ssp_pkg::SRC_REG: v = rd;
      ssp_pkg::SRC_K60: v = ssp_pkg::K60_TAB[o.idx];
      ssp_pkg::SRC_K40: v = ssp_pkg::K40_TAB[o.idx];
      ssp_pkg::SRC_IN: begin
        unique case (o.idx)
          ssp_pkg::IN_T:   v = {{(64-ssp_pkg::TEMP_W){it.temp[ssp_pkg::TEMP_W-1]}}, it.temp};
          ssp_pkg::IN_S:   v = {{(64-ssp_pkg::SAL_W){1'b0}}, it.sal};
          ssp_pkg::IN_Z:   v = {{(24-ssp_pkg::DEPTH_W){1'b0}}, it.depth, 40'd0};
          ssp_pkg::IN_LAT: v = {{(40-ssp_pkg::LAT_W){1'b0}}, lat, 24'd0};
          ssp_pkg::IN_ONE: v = 64'sd1 << 40;
          ssp_pkg::IN_THOUSAND: v = 64'sd1000;
          default: v = '0;
        endcase
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  assign uop = ssp_pkg::uop_at(pc);
  assign opa = pick(uop.a, rda, cur, lat_sin_sq_q16);
  assign opb = pick(uop.b, rdb, cur, lat_sin_sq_q16);

  ssp_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (opa),
    .b      (opb),
    .sh     (uop.sh),
    .done   (mul_done),
    .result (mul_res)
  );

  always_comb begin
    if (!v_pos) begin
      vel_res = '0;
    end else if (mul_res > 64'(ssp_pkg::VEL_MAX)) begin
      vel_res = ssp_pkg::VEL_W'(ssp_pkg::VEL_MAX);
    end else begin
      vel_res = mul_res[ssp_pkg::VEL_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    q_pop      = 1'b0;
    mul_start  = 1'b0;
    rf_we      = 1'b0;
    rf_wdata   = opa + opb;
    load_zero  = 1'b0;
    load_res   = 1'b0;
    unique case (state)
      ssp_pkg::BK_IDLE: begin
        // take the next request only once the result register is free
        if (q_valid && !rsp_valid) begin
          q_pop = 1'b1;
          if (q_item.have) begin
            pc_next    = '0;
            state_next = ssp_pkg::BK_FETCH;
          end else begin
            load_zero = 1'b1;
          end
        end
      end
      ssp_pkg::BK_FETCH: state_next = ssp_pkg::BK_EXEC;
      ssp_pkg::BK_EXEC: begin
        if (uop.op == ssp_pkg::OP_MUL) begin
          mul_start  = 1'b1;
          state_next = ssp_pkg::BK_MULW;
        end else begin
          rf_we      = 1'b1;
          pc_next    = pc + ssp_pkg::PC_W'(1);
          state_next = ssp_pkg::BK_FETCH;
        end
      end
      ssp_pkg::BK_MULW: begin
        if (mul_done) begin
          if (uop.last) begin
            load_res   = 1'b1;
            state_next = ssp_pkg::BK_IDLE;
          end else begin
            rf_we      = 1'b1;
            rf_wdata   = mul_res;
            pc_next    = pc + ssp_pkg::PC_W'(1);
            state_next = ssp_pkg::BK_FETCH;
          end
        end
      end
      default: state_next = ssp_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ssp_pkg::BK_IDLE;
      pc             <= '0;
      lat_sin_sq_q16 <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (cfg_we) begin
        lat_sin_sq_q16 <= cfg_data;
      end
      if (load_zero || load_res) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[uop.dst] <= rf_wdata;
    end
    rda <= rf[uop.a.idx[ssp_pkg::REG_AW-1:0]];
    rdb <= rf[uop.b.idx[ssp_pkg::REG_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    // the speed counts only where the polynomial came out positive
    if (state == ssp_pkg::BK_EXEC && uop.last) begin
      v_pos <= (opa > 64'sd0);
    end
    if (load_zero) begin
      velocity_mmps  <= '0;
      velocity_valid <= 1'b0;
      from_held      <= 1'b0;
    end else if (load_res) begin
      velocity_mmps  <= vel_res;
      velocity_valid <= 1'b1;
      from_held      <= cur.held;
    end
  end

endmodule

/* sim/tb_top.sv */
// Self-checking testbench of the profile sound speed block.
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [ssp_pkg::VEL_W-1:0] speed;
    logic                      speed_ok;
    logic                      held;
  } speed_exp_t;

  class speed_scoreboard;
    speed_exp_t                        speed_q[$];
    logic signed [ssp_pkg::TEMP_W-1:0] held_temp;
    logic [ssp_pkg::SAL_W-1:0]         held_sal;
    logic                              have_sample;
    logic [ssp_pkg::LAT_W-1:0]         lat_q16;
    int                                errors;

    function void clear();
      speed_q.delete();
      held_temp = '0;
      held_sal = '0;
      have_sample = 1'b0;
      lat_q16 = '0;
      errors = 0;
    endfunction

    // round(num / den * 2^bits), ties up, with sign
    function logic signed [63:0] coef(input int k, input int bits);
      logic [127:0] q;
      logic [127:0] r;
      logic [127:0] n;
      logic [63:0]  mag;
      n = {64'd0, ssp_pkg::K_NUM[k]} << bits;
      q = n / {64'd0, ssp_pkg::K_DEN[k]};
      r = n % {64'd0, ssp_pkg::K_DEN[k]};
      mag = q[63:0];
      if ((r << 1) >= {64'd0, ssp_pkg::K_DEN[k]}) mag = mag + 64'd1;
      if (k inside {ssp_pkg::K_T2, ssp_pkg::K_P3, ssp_pkg::K_B, ssp_pkg::K_D, ssp_pkg::K_E,
                    ssp_pkg::K_F, ssp_pkg::K_J}) return -$signed(mag);
      return $signed(mag);
    endfunction

    // a * b / 2^sh, rounded away from zero on ties, magnitude capped at 2^62
    function logic signed [63:0] scale_mul(input logic signed [63:0] a,
                                           input logic signed [63:0] b, input int sh);
      logic         neg;
      logic [127:0] ua;
      logic [127:0] ub;
      logic [127:0] pr;
      neg = (a < 0) != (b < 0);
      ua = {64'd0, (a < 0) ? 64'(-a) : 64'(a)};
      ub = {64'd0, (b < 0) ? 64'(-b) : 64'(b)};
      pr = (ua * ub + (128'd1 << (sh - 1))) >> sh;
      if (pr > (128'd1 << 62)) pr = 128'd1 << 62;
      return neg ? -$signed(pr[63:0]) : $signed(pr[63:0]);
    endfunction

    function logic signed [63:0] qm(input logic signed [63:0] a, input logic signed [63:0] b);
      return scale_mul(a, b, 40);
    endfunction
    function logic signed [63:0] kx(input int k, input logic signed [63:0] x);
      return scale_mul(coef(k, 60), x, 60);
    endfunction
    function logic signed [63:0] ka(input int k);
      return coef(k, 40);
    endfunction

    function logic [ssp_pkg::VEL_W-1:0] speed_mmps(
        input logic [ssp_pkg::DEPTH_W-1:0] depth,
        input logic signed [ssp_pkg::TEMP_W-1:0] t_mc,
        input logic [ssp_pkg::SAL_W-1:0] s_mpsu);
      logic signed [63:0] z, t, s, lat, p, p_lin, p_quad, d_t, d_s, d_p;
      logic signed [63:0] in2, in3, in4, part1, part2, v, mm;
      z = 64'(depth) <<< 40;
      t = scale_mul(64'(t_mc), coef(ssp_pkg::K_MILLI, 60), 20);
      s = scale_mul(64'(s_mpsu), coef(ssp_pkg::K_MILLI, 60), 20);
      lat = (64'sd1 <<< 40) + kx(ssp_pkg::K_LAT, 64'(lat_q16) <<< 24);
      p_lin = qm(kx(ssp_pkg::K_LIN, z), lat);
      p_quad = qm(kx(ssp_pkg::K_QUAD, z), z);
      p = kx(ssp_pkg::K_KG, p_lin + p_quad);
      d_t = qm(t, ka(ssp_pkg::K_T1) + qm(t, ka(ssp_pkg::K_T2) + kx(ssp_pkg::K_T3, t)));
      d_s = qm(s, ka(ssp_pkg::K_S1) + kx(ssp_pkg::K_S2, s));
      d_p = qm(p, ka(ssp_pkg::K_P1) + qm(p, ka(ssp_pkg::K_P2) + kx(ssp_pkg::K_P3, p)));
      in3 = kx(ssp_pkg::K_A, t) + ka(ssp_pkg::K_B) + kx(ssp_pkg::K_C, p);
      in2 = ka(ssp_pkg::K_TP) + qm(p, in3) + qm(kx(ssp_pkg::K_D, t), t);
      part1 = qm(t, kx(ssp_pkg::K_E, s) + qm(p, in2));
      in4 = kx(ssp_pkg::K_H, s) + ka(ssp_pkg::K_J);
      part2 = qm(s, qm(qm(kx(ssp_pkg::K_F, s), p), p)
                    + qm(t, kx(ssp_pkg::K_G, t) + qm(p, in4)));
      v = ka(ssp_pkg::K_C0) + d_t + d_s + d_p + part1 + part2;
      if (v <= 0) return '0;
      mm = scale_mul(v, 64'sd1000, 40);
      if (mm > ssp_pkg::VEL_MAX) mm = ssp_pkg::VEL_MAX;
      return mm[ssp_pkg::VEL_W-1:0];
    endfunction

    function void note_request(input logic [ssp_pkg::DEPTH_W-1:0] depth,
                               input logic signed [ssp_pkg::TEMP_W-1:0] temp,
                               input logic [ssp_pkg::SAL_W-1:0] sal, input logic valid,
                               input logic start);
      speed_exp_t e;
      logic used_held;
      used_held = 1'b0;
      if (start) begin
        held_temp = '0;
        held_sal = '0;
        have_sample = 1'b0;
      end
      if (valid) begin
        held_temp = temp;
        held_sal = sal;
        have_sample = 1'b1;
      end else begin
        used_held = have_sample;
      end
      if (!have_sample) begin
        e = '{speed: '0, speed_ok: 1'b0, held: 1'b0};
      end else begin
        e = '{speed: speed_mmps(depth, held_temp, held_sal), speed_ok: 1'b1,
              held: used_held};
      end
      speed_q.push_back(e);
    endfunction

    function void check_result(input logic [ssp_pkg::VEL_W-1:0] speed, input logic speed_ok,
                               input logic held);
      speed_exp_t e;
      if (speed_q.size() == 0) begin
        $display("%0t: result with none outstanding: speed %0d valid %0b held %0b",
                 $time, speed, speed_ok, held);
        errors++;
        return;
      end
      e = speed_q.pop_front();
      if (speed !== e.speed) begin
        $display("%0t: velocity_mmps expected %0d actual %0d", $time, e.speed, speed);
        errors++;
      end
      if (speed_ok !== e.speed_ok) begin
        $display("%0t: velocity_valid expected %0b actual %0b", $time, e.speed_ok, speed_ok);
        errors++;
      end
      if (held !== e.held) begin
        $display("%0t: from_held expected %0b actual %0b", $time, e.held, held);
        errors++;
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [ssp_pkg::LAT_W-1:0]         cfg_data;
  logic                              req_valid;
  logic                              req_stall;
  logic [ssp_pkg::DEPTH_W-1:0]       depth_m;
  logic signed [ssp_pkg::TEMP_W-1:0] temperature_mc;
  logic [ssp_pkg::SAL_W-1:0]         salinity_mpsu;
  logic                              sample_valid;
  logic                              profile_start;
  logic                              rsp_valid;
  logic                              rsp_stall;
  logic [ssp_pkg::VEL_W-1:0]         velocity_mmps;
  logic                              velocity_valid;
  logic                              from_held;

  speed_scoreboard sb;
  logic            calm;
  int              quiet_cycles;

  sound_speed_profile_delgrosso_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .depth_m(depth_m),
    .temperature_mc(temperature_mc), .salinity_mpsu(salinity_mpsu),
    .sample_valid(sample_valid), .profile_start(profile_start),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .velocity_mmps(velocity_mmps),
    .velocity_valid(velocity_valid), .from_held(from_held)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || calm) rsp_stall <= 1'b0;
    else rsp_stall <= ($urandom_range(99) < 14);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(velocity_mmps, velocity_valid, from_held);
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_level(input logic [ssp_pkg::DEPTH_W-1:0] d,
                            input logic signed [ssp_pkg::TEMP_W-1:0] t,
                            input logic [ssp_pkg::SAL_W-1:0] s, input logic v, input logic st);
    if (!calm && $urandom_range(99) < 14) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    req_valid <= 1'b1;
    depth_m <= d;
    temperature_mc <= t;
    salinity_mpsu <= s;
    sample_valid <= v;
    profile_start <= st;
    do @(posedge clk); while (req_stall);
    sb.note_request(d, t, s, v, st);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.speed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_lat(input logic [ssp_pkg::LAT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.lat_q16 = val;
  endtask

  // mostly profiles in range, some full-width noise
  task automatic random_level();
    logic [ssp_pkg::DEPTH_W-1:0] d;
    logic [ssp_pkg::TEMP_W-1:0]  t;
    logic [ssp_pkg::SAL_W-1:0]   s;
    d = ($urandom_range(99) < 85) ? ssp_pkg::DEPTH_W'($urandom_range(12000))
                                  : ssp_pkg::DEPTH_W'($urandom);
    t = ($urandom_range(99) < 85) ? ssp_pkg::TEMP_W'(int'($urandom_range(45000)) - 5000)
                                  : ssp_pkg::TEMP_W'($urandom);
    s = ($urandom_range(99) < 85) ? ssp_pkg::SAL_W'($urandom_range(45000))
                                  : ssp_pkg::SAL_W'($urandom);
    send_level(d, t, s, $urandom_range(99) < 65, $urandom_range(99) < 6);
  endtask

  initial begin
    logic [ssp_pkg::LAT_W-1:0] lat_set [4];
    sb = new();
    sb.clear();
    calm = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    req_valid <= 1'b0;
    depth_m <= '0;
    temperature_mc <= '0;
    salinity_mpsu <= '0;
    sample_valid <= 1'b0;
    profile_start <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no sample yet, then extremes, held reuse and profile restarts
    write_lat(17'd0);
    send_level(14'd100, 17'sd0, 16'd0, 1'b0, 1'b0);
    send_level(14'd0, -17'sd5000, 16'd0, 1'b1, 1'b1);
    send_level(14'd500, 17'sd0, 16'd0, 1'b0, 1'b0);
    send_level(14'd12000, 17'sd40000, 16'd45000, 1'b1, 1'b0);
    send_level(14'd16383, 17'sd0, 16'd0, 1'b0, 1'b0);
    send_level(14'd3000, 17'sd20000, 16'd35000, 1'b0, 1'b1);
    send_level(14'd3000, 17'sd20000, 16'd35000, 1'b1, 1'b1);
    send_level(14'd16383, -17'sd65536, 16'd65535, 1'b1, 1'b0);
    send_level(14'd16383, 17'sd65535, 16'd65535, 1'b1, 1'b0);
    send_level(14'd0, 17'sd65535, 16'd0, 1'b1, 1'b0);
    send_level(14'd8191, -17'sd1, 16'd32768, 1'b1, 1'b0);
    send_level(14'd0, 17'sd0, 16'd0, 1'b0, 1'b0);
    drain();
    write_lat(17'd65536);
    send_level(14'd12000, 17'sd2000, 16'd34700, 1'b1, 1'b1);
    send_level(14'd16383, 17'sd0, 16'd0, 1'b0, 1'b0);
    drain();
    write_lat(17'd131071);
    send_level(14'd16383, 17'sd1000, 16'd35000, 1'b1, 1'b1);
    send_level(14'd6000, 17'sd0, 16'd0, 1'b0, 1'b0);
    drain();

    lat_set = '{17'd0, 17'd65536, ssp_pkg::LAT_W'($urandom_range(65536)),
                ssp_pkg::LAT_W'($urandom)};
    for (int ph = 0; ph < 4; ph++) begin
      write_lat(lat_set[ph]);
      calm = (ph == 1);
      for (int i = 0; i < 200; i++) begin
        if (ph == 2 && i == 100) drain();
        random_level();
      end
      drain();
    end
    calm = 1'b0;

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.speed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
